FILE: rtl/dsac_pkg.sv
`timescale 1ns / 1ps
// Package for the decimal scale-align compare block.
// Holds widths, divide-by-ten constants and the controller/datapath command types.
package dsac_pkg;

  localparam int MANT_W     = 96;
  localparam int LIMB_W     = 32;
  localparam int LIMBS      = MANT_W / LIMB_W;
  localparam int LIMB_IDX_W = 2;
  localparam int SCALE_W    = 5;
  localparam int REM_W      = 4;
  localparam int CUR_W      = REM_W + LIMB_W;
  localparam int MAGIC_W    = 36;
  localparam int DIV_SHIFT  = 39;

  // ceil(2^39 / 10): exact quotient for any numerator below 10 * 2^32
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 36'hCCCCCCCCD;
  localparam logic [LIMB_IDX_W-1:0] LIMB_TOP = LIMB_IDX_W'(LIMBS - 1);

  typedef struct packed {
    logic                  load;
    logic                  mul;
    logic                  div;
    logic                  div_first;
    logic                  div_last;
    logic [LIMB_IDX_W-1:0] limb;
    logic                  capture;
  } dsac_cmd_t;

  typedef struct packed {
    logic lt;
    logic mul_ovf;
  } dsac_sts_t;

endpackage

FILE: rtl/dsac_datapath.sv
`timescale 1ns / 1ps
// Datapath: mantissa and scale registers, x10 step, limb-wise /10 step, compare.
// Depends on dsac_pkg; driven by dsac_ctrl.
module dsac_datapath
  import dsac_pkg::*;
(
  input  logic               clk,
  input  logic [63:0]        in_a_mantissa_low,
  input  logic [31:0]        in_a_mantissa_high,
  input  logic [SCALE_W-1:0] in_a_scale,
  input  logic [63:0]        in_b_mantissa_low,
  input  logic [31:0]        in_b_mantissa_high,
  input  logic [SCALE_W-1:0] in_b_scale,
  input  dsac_cmd_t          cmd,
  output dsac_sts_t          sts,
  output logic               out_a_greater,
  output logic [SCALE_W-1:0] out_common_scale
);

  logic [MANT_W-1:0]  lo_m_r, lo_m_nxt;
  logic [MANT_W-1:0]  hi_m_r, hi_m_nxt;
  logic [SCALE_W-1:0] lo_s_r, lo_s_nxt;
  logic [SCALE_W-1:0] hi_s_r, hi_s_nxt;
  logic               a_is_lo_r, a_is_lo_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               gt_r, gt_nxt;
  logic [SCALE_W-1:0] cs_r, cs_nxt;

  logic [MANT_W-1:0]         a_in, b_in;
  logic [MANT_W+3:0]         m10;
  logic [LIMB_W-1:0]         limb_val;
  logic [CUR_W-1:0]          cur;
  logic [CUR_W+MAGIC_W-1:0]  prod;
  logic [LIMB_W-1:0]         quot;
  logic [CUR_W-1:0]          quot10;
  logic [CUR_W-1:0]          rem_full;
  logic [MANT_W-1:0]         a_al, b_al;

  assign a_in = {in_a_mantissa_high, in_a_mantissa_low};
  assign b_in = {in_b_mantissa_high, in_b_mantissa_low};

  // x10 as 8x + 2x
  assign m10 = ({4'b0, lo_m_r} << 3) + ({4'b0, lo_m_r} << 1);

  always_comb begin
    case (cmd.limb)
      2'd0:    limb_val = hi_m_r[LIMB_W-1:0];
      2'd1:    limb_val = hi_m_r[2*LIMB_W-1:LIMB_W];
      default: limb_val = hi_m_r[3*LIMB_W-1:2*LIMB_W];
    endcase
  end

  assign cur      = {(cmd.div_first ? {REM_W{1'b0}} : rem_r), limb_val};
  assign prod     = {{MAGIC_W{1'b0}}, cur} * {{CUR_W{1'b0}}, DIV_MAGIC};
  assign quot     = prod[DIV_SHIFT +: LIMB_W];
  assign quot10   = ({4'b0, quot} << 3) + ({4'b0, quot} << 1);
  assign rem_full = cur - quot10;

  assign sts.lt      = lo_s_r < hi_s_r;
  assign sts.mul_ovf = |m10[MANT_W+3:MANT_W];

  assign a_al = a_is_lo_r ? lo_m_r : hi_m_r;
  assign b_al = a_is_lo_r ? hi_m_r : lo_m_r;

  always_comb begin
    lo_m_nxt    = lo_m_r;
    hi_m_nxt    = hi_m_r;
    lo_s_nxt    = lo_s_r;
    hi_s_nxt    = hi_s_r;
    a_is_lo_nxt = a_is_lo_r;
    rem_nxt     = rem_r;
    gt_nxt      = gt_r;
    cs_nxt      = cs_r;
    if (cmd.load) begin
      a_is_lo_nxt = in_a_scale < in_b_scale;
      if (in_a_scale < in_b_scale) begin
        lo_m_nxt = a_in;
        lo_s_nxt = in_a_scale;
        hi_m_nxt = b_in;
        hi_s_nxt = in_b_scale;
      end else begin
        lo_m_nxt = b_in;
        lo_s_nxt = in_b_scale;
        hi_m_nxt = a_in;
        hi_s_nxt = in_a_scale;
      end
    end
    if (cmd.mul) begin
      lo_m_nxt = m10[MANT_W-1:0];
      lo_s_nxt = lo_s_r + SCALE_W'(1);
    end
    if (cmd.div) begin
      rem_nxt = rem_full[REM_W-1:0];
      case (cmd.limb)
        2'd0:    hi_m_nxt[LIMB_W-1:0]          = quot;
        2'd1:    hi_m_nxt[2*LIMB_W-1:LIMB_W]   = quot;
        default: hi_m_nxt[3*LIMB_W-1:2*LIMB_W] = quot;
      endcase
      if (cmd.div_last) begin
        hi_s_nxt = hi_s_r - SCALE_W'(1);
      end
    end
    if (cmd.capture) begin
      gt_nxt = a_al > b_al;
      cs_nxt = lo_s_r;
    end
  end

  always_ff @(posedge clk) begin
    lo_m_r    <= lo_m_nxt;
    hi_m_r    <= hi_m_nxt;
    lo_s_r    <= lo_s_nxt;
    hi_s_r    <= hi_s_nxt;
    a_is_lo_r <= a_is_lo_nxt;
    rem_r     <= rem_nxt;
    gt_r      <= gt_nxt;
    cs_r      <= cs_nxt;
  end

  assign out_a_greater    = gt_r;
  assign out_common_scale = cs_r;

endmodule

FILE: rtl/dsac_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences load, x10 steps, limb-wise /10 steps and result capture.
// Depends on dsac_pkg; drives dsac_datapath.
module dsac_ctrl
  import dsac_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dsac_sts_t sts,
  output dsac_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_CMP  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [LIMB_IDX_W-1:0] limb_r, limb_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt     = state_r;
    limb_nxt      = limb_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.limb      = limb_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        limb_nxt = LIMB_TOP;
        if (!sts.lt) begin
          state_nxt = S_CMP;
        end else if (sts.mul_ovf) begin
          state_nxt = S_DIV;
        end else begin
          cmd.mul = 1'b1;
        end
      end
      S_DIV: begin
        if (limb_r == LIMB_TOP && !sts.lt) begin
          state_nxt = S_CMP;
        end else begin
          cmd.div       = 1'b1;
          cmd.div_first = limb_r == LIMB_TOP;
          cmd.div_last  = limb_r == '0;
          limb_nxt      = (limb_r == '0) ? LIMB_TOP : limb_r - 1'b1;
        end
      end
      S_CMP: begin
        if (out_free) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limb_r      <= LIMB_TOP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limb_r      <= limb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_capture_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("result capture did not raise out_valid");

  a_limb_range: assert property (@(posedge clk) disable iff (!rst_n)
    limb_r <= LIMB_TOP)
    else $error("limb index out of range");

  a_div_starts_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL && sts.lt && sts.mul_ovf |=> state_r == S_DIV && limb_r == LIMB_TOP)
    else $error("divide phase entered mid-word");

  a_no_capture_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !cmd.capture)
    else $error("result overwritten while stalled");

endmodule

FILE: rtl/decimal_scale_align_compare.sv
`timescale 1ns / 1ps
// m = x10 steps tried (a refused step counts), d = /10 steps; m + d <= 32.
// One word at a time: the next input is taken the cycle after the result is registered,
// and out_stall holds the compare. The /10 unit works one 32-bit limb per cycle,
// and each decimal step passes over all three limbs, top limb first.
// Synchronous active-low reset clears the controller and out_valid; no clearing pass.
module decimal_scale_align_compare
  import dsac_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_a_mantissa_low,
  input  logic [31:0]        in_a_mantissa_high,
  input  logic [SCALE_W-1:0] in_a_scale,
  input  logic [63:0]        in_b_mantissa_low,
  input  logic [31:0]        in_b_mantissa_high,
  input  logic [SCALE_W-1:0] in_b_scale,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_a_greater,
  output logic [SCALE_W-1:0] out_common_scale
);

  dsac_cmd_t cmd;
  dsac_sts_t sts;

  dsac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dsac_datapath u_dp (
    .clk                (clk),
    .in_a_mantissa_low  (in_a_mantissa_low),
    .in_a_mantissa_high (in_a_mantissa_high),
    .in_a_scale         (in_a_scale),
    .in_b_mantissa_low  (in_b_mantissa_low),
    .in_b_mantissa_high (in_b_mantissa_high),
    .in_b_scale         (in_b_scale),
    .cmd                (cmd),
    .sts                (sts),
    .out_a_greater      (out_a_greater),
    .out_common_scale   (out_common_scale)
  );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for decimal_scale_align_compare: queued input words, random gaps
// and stalls, and an internal scale-align-compare predictor checked against each result.
// Depends on dsac_pkg and the decimal_scale_align_compare RTL.
module tb;
  import dsac_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int CALM_TAIL      = 100;
  localparam int RANDOM_WORDS   = 1250;

  typedef struct packed {
    logic [MANT_W-1:0]  a_mant;
    logic [SCALE_W-1:0] a_scale;
    logic [MANT_W-1:0]  b_mant;
    logic [SCALE_W-1:0] b_scale;
  } word_t;

  typedef struct packed {
    logic               a_greater;
    logic [SCALE_W-1:0] common_scale;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [63:0]        in_a_mantissa_low = '0;
  logic [31:0]        in_a_mantissa_high = '0;
  logic [SCALE_W-1:0] in_a_scale = '0;
  logic [63:0]        in_b_mantissa_low = '0;
  logic [31:0]        in_b_mantissa_high = '0;
  logic [SCALE_W-1:0] in_b_scale = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_a_greater;
  logic [SCALE_W-1:0] out_common_scale;

  word_t    pending_words[$];
  verdict_t expected_verdicts[$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_hold = 0;
  int gap_pct = 25;
  int stall_pct = 25;

  always #5 clk = ~clk;

  decimal_scale_align_compare i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_a_mantissa_low (in_a_mantissa_low),
    .in_a_mantissa_high(in_a_mantissa_high),
    .in_a_scale        (in_a_scale),
    .in_b_mantissa_low (in_b_mantissa_low),
    .in_b_mantissa_high(in_b_mantissa_high),
    .in_b_scale        (in_b_scale),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_a_greater     (out_a_greater),
    .out_common_scale  (out_common_scale)
  );

  // Lower-scale side is scaled up by ten until it matches or would overflow 96 bits,
  // then the other side is divided down (truncating) to the reached scale.
  function automatic verdict_t align_and_compare(logic [MANT_W-1:0] a_mant,
                                                  logic [SCALE_W-1:0] a_scale,
                                                  logic [MANT_W-1:0] b_mant,
                                                  logic [SCALE_W-1:0] b_scale);
    logic [MANT_W-1:0]  up_mant, down_mant;
    logic [SCALE_W-1:0] up_scale, down_scale;
    logic [MANT_W+3:0]  product;
    bit                 a_is_up;
    bit                 refused;
    verdict_t           v;
    a_is_up = a_scale < b_scale;
    up_mant    = a_is_up ? a_mant : b_mant;
    up_scale   = a_is_up ? a_scale : b_scale;
    down_mant  = a_is_up ? b_mant : a_mant;
    down_scale = a_is_up ? b_scale : a_scale;
    refused = 1'b0;
    while (up_scale < down_scale && !refused) begin
      product = {4'b0, up_mant} * (MANT_W + 4)'(10);
      if (product[MANT_W+3:MANT_W] != '0) begin
        refused = 1'b1;
      end else begin
        up_mant  = product[MANT_W-1:0];
        up_scale = up_scale + 1'b1;
      end
    end
    while (up_scale < down_scale) begin
      down_mant  = down_mant / MANT_W'(10);
      down_scale = down_scale - 1'b1;
    end
    v.a_greater    = a_is_up ? (up_mant > down_mant) : (down_mant > up_mant);
    v.common_scale = up_scale;
    return v;
  endfunction

  function automatic logic [MANT_W-1:0] pow_ten(int k);
    logic [MANT_W-1:0] p;
    p = MANT_W'(1);
    repeat (k) p = p * MANT_W'(10);
    return p;
  endfunction

  function automatic logic [MANT_W-1:0] rand_mantissa();
    logic [MANT_W-1:0] full;
    full = {$urandom, $urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return full;
      1: return MANT_W'($urandom_range(0, 1000));
      2: return {MANT_W{1'b1}} - MANT_W'($urandom_range(0, 1000));
      3: return pow_ten($urandom_range(0, 28)) * MANT_W'($urandom_range(1, 9));
      4: return full >> $urandom_range(0, 95);
      default: return '0;
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    if ($urandom_range(0, 9) == 0) return SCALE_W'($urandom_range(29, 31));
    return SCALE_W'($urandom_range(0, 28));
  endfunction

  task automatic add_word(logic [MANT_W-1:0] a_mant, logic [SCALE_W-1:0] a_scale,
                          logic [MANT_W-1:0] b_mant, logic [SCALE_W-1:0] b_scale);
    word_t w;
    w.a_mant  = a_mant;
    w.a_scale = a_scale;
    w.b_mant  = b_mant;
    w.b_scale = b_scale;
    pending_words.push_back(w);
  endtask

  task automatic note_mismatch(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // driver
  always @(posedge clk) begin : drive_words
    word_t w;
    bit    calm;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!(in_valid && in_stall)) begin
      calm = pending_words.size() < CALM_TAIL;
      if (in_valid) begin
        expected_verdicts.push_back(align_and_compare(
            {in_a_mantissa_high, in_a_mantissa_low}, in_a_scale,
            {in_b_mantissa_high, in_b_mantissa_low}, in_b_scale));
        if ($urandom_range(0, 49) == 0) gap_pct = 25 * $urandom_range(0, 2);
      end
      if (in_gap > 0 && !calm) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
        in_gap   <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        in_a_mantissa_low  <= w.a_mant[63:0];
        in_a_mantissa_high <= w.a_mant[MANT_W-1:64];
        in_a_scale         <= w.a_scale;
        in_b_mantissa_low  <= w.b_mant[63:0];
        in_b_mantissa_high <= w.b_mant[MANT_W-1:64];
        in_b_scale         <= w.b_scale;
        in_valid           <= 1'b1;
        in_gap             <= 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          note_mismatch("unexpected word, a_greater", -1, out_a_greater);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_a_greater !== want.a_greater)
            note_mismatch("a_greater", want.a_greater, out_a_greater);
          if (out_common_scale !== want.common_scale)
            note_mismatch("common_scale", want.common_scale, out_common_scale);
          if ($urandom_range(0, 49) == 0) stall_pct = 25 * $urandom_range(0, 2);
        end
      end
      if (pending_words.size() < CALM_TAIL) begin
        out_stall <= 1'b0;
        out_hold  <= 0;
      end else if (out_hold > 0) begin
        out_hold  <= out_hold - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_hold  <= $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [MANT_W-1:0]  m, scaled;
    logic [SCALE_W-1:0] sa;
    int                 k;
    logic [MANT_W-1:0]  all_ones;
    all_ones = {MANT_W{1'b1}};

    // directed: extremes, equal scales, refused multiply, truncation, scales above 28
    add_word('0, 0, '0, 0);
    add_word(all_ones, 0, all_ones, 0);
    add_word(all_ones, 28, all_ones, 0);
    add_word(MANT_W'(1), 0, all_ones, 28);
    add_word(MANT_W'(1), 0, MANT_W'(10), 1);
    add_word(MANT_W'(2), 0, MANT_W'(19), 1);
    add_word(MANT_W'(15), 1, MANT_W'(1), 0);
    add_word(MANT_W'(1) << 90, 0, MANT_W'(1), 28);
    add_word(MANT_W'(1), 28, MANT_W'(1) << 90, 0);
    add_word(MANT_W'(5), 31, MANT_W'(5), 0);
    add_word('0, 31, '0, 29);
    add_word(all_ones, 31, MANT_W'(1), 31);
    add_word({32'hFFFF_FFFF, 64'h0}, 3, {32'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 3);
    add_word(MANT_W'(123456789), 12, MANT_W'(123456789), 12);
    add_word(pow_ten(28), 28, MANT_W'(1), 0);
    add_word(MANT_W'(1), 0, pow_ten(28) - 1, 28);
    add_word(MANT_W'(7), 5, MANT_W'(70000), 9);
    add_word(all_ones, 1, all_ones / MANT_W'(10), 0);
    add_word(all_ones / MANT_W'(10), 0, all_ones, 1);
    add_word(MANT_W'(3), 30, all_ones, 2);

    repeat (RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // pair that aligns close to equality, nudged by at most one
          k  = $urandom_range(0, 14);
          m  = rand_mantissa() >> $urandom_range(0, 60);
          sa = ($urandom_range(0, 9) == 0) ? SCALE_W'($urandom_range(0, 31 - k))
                                           : SCALE_W'($urandom_range(0, 28 - k));
          scaled = m * pow_ten(k) + MANT_W'($urandom_range(0, 2)) - MANT_W'(1);
          if ($urandom_range(0, 1))
            add_word(m, sa, scaled, sa + SCALE_W'(k));
          else
            add_word(scaled, sa + SCALE_W'(k), m, sa);
        end
        6: begin
          sa = rand_scale();
          add_word(rand_mantissa(), sa, rand_mantissa(), sa);
        end
        default: add_word(rand_mantissa(), rand_scale(), rand_mantissa(), rand_scale());
      endcase
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
